// ===== hw/rtl/tvl_pkg.sv =====
// Shared types, codes and the Kleene node function for the query tree evaluator.
package tvl_pkg;

  localparam logic [1:0] KIND_BEGIN  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_SET    = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [2:0] OP_NOT    = 3'd0;
  localparam logic [2:0] OP_AND    = 3'd1;
  localparam logic [2:0] OP_OR     = 3'd2;
  localparam logic [2:0] OP_ADD    = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  localparam logic [1:0] VAL_UNK   = 2'd0;
  localparam logic [1:0] VAL_FALSE = 2'd1;
  localparam logic [1:0] VAL_TRUE  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MALFORMED  = 2'd1;
  localparam logic [1:0] ST_IGNORED    = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       element_is_leaf;
    logic [2:0] operator_code;
    logic [5:0] leaf_index;
    logic [1:0] leaf_value;
  } req_t;

  typedef struct packed {
    logic [1:0] tree_state;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_leaf;
    logic [2:0] op;
    logic       op_bad;
    logic       unary;
    logic [5:0] leaf;
    logic [1:0] value;
  } cmd_t;

  function automatic logic [1:0] kleene_eval(input logic [2:0] op, input logic [1:0] l,
                                             input logic [1:0] r, input logic [1:0] old);
    logic [1:0] res;
    res = old;
    case (op)
      OP_NOT: begin
        if (l == VAL_FALSE) res = VAL_TRUE;
        else if (l == VAL_TRUE) res = VAL_FALSE;
        else res = VAL_UNK;
      end
      OP_AND: begin
        if (l == VAL_FALSE || r == VAL_FALSE) res = VAL_FALSE;
        else if (l == VAL_UNK || r == VAL_UNK) res = VAL_UNK;
        else res = VAL_TRUE;
      end
      OP_OR, OP_ADD: begin
        if (l == VAL_TRUE || r == VAL_TRUE) res = VAL_TRUE;
        else if (l == VAL_UNK || r == VAL_UNK) res = VAL_UNK;
        else res = VAL_FALSE;
      end
      OP_REMOVE: begin
        if (l == VAL_FALSE || r == VAL_TRUE) res = VAL_FALSE;
        else if (l == VAL_UNK || r == VAL_UNK) res = VAL_UNK;
        else res = VAL_TRUE;
      end
      default: res = old;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/tvl_front.sv =====
// Request intake: decode each request into a command and hold it in a two-entry queue.
module tvl_front import tvl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic q_pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.kind    = req.kind;
    dec.is_leaf = req.element_is_leaf;
    dec.op      = req.operator_code;
    dec.op_bad  = req.operator_code > OP_REMOVE;
    dec.unary   = req.operator_code == OP_NOT;
    dec.leaf    = req.leaf_index;
    dec.value   = (req.leaf_value == 2'd3) ? VAL_UNK : req.leaf_value;
  end

  assign req_stall = count == 2'd2;
  assign push      = req_valid && !req_stall;
  assign q_valid   = count != 2'd0;
  assign q_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/tvl_back.sv =====
// Command sequencer: builds the tree in node memories, propagates leaf updates, sweeps clears.
module tvl_back import tvl_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = NW + 1;
  localparam int XW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] NONE = CW'(MAX_NODES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POP1 = 4'd1;
  localparam logic [3:0] S_POP2 = 4'd2;
  localparam logic [3:0] S_SET1 = 4'd3;
  localparam logic [3:0] S_SET2 = 4'd4;
  localparam logic [3:0] S_W1   = 4'd5;
  localparam logic [3:0] S_W2   = 4'd6;
  localparam logic [3:0] S_W3   = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  logic [2:0]    op_mem    [MAX_NODES];
  logic [1:0]    val_mem   [MAX_NODES];
  logic [CW-1:0] par_mem   [MAX_NODES];
  logic [NW-1:0] left_mem  [MAX_NODES];
  logic [CW-1:0] right_mem [MAX_NODES];
  logic [NW-1:0] l2n_mem   [MAX_NODES];
  logic [NW-1:0] stk_mem   [MAX_NODES];

  logic          op_we, val_we, par_we, left_we, right_we, l2n_we, stk_we;
  logic [NW-1:0] op_wa, val_wa, par_wa, left_wa, right_wa, l2n_wa, stk_wa;
  logic [2:0]    op_wd;
  logic [1:0]    val_wd;
  logic [CW-1:0] par_wd, right_wd;
  logic [NW-1:0] left_wd, l2n_wd, stk_wd;
  logic [NW-1:0] node_ra, val_ra, l2n_ra, stk_ra;
  logic [2:0]    op_rd;
  logic [1:0]    val_rd;
  logic [CW-1:0] par_rd, right_rd;
  logic [NW-1:0] left_rd, l2n_rd, stk_rd;

  logic [3:0]    state, state_next;
  logic [CW-1:0] stack_depth, stack_depth_next;
  logic [CW-1:0] node_total, node_total_next;
  logic [CW-1:0] leaf_total, leaf_total_next;
  logic [1:0]    root_value, root_value_next;
  cmd_t          cmd, cmd_next;
  logic [NW-1:0] cur, cur_next;
  logic [CW-1:0] par, par_next;
  logic [CW-1:0] rc, rc_next;
  logic [2:0]    opr, opr_next;
  logic [1:0]    old, old_next;
  logic [1:0]    lval, lval_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;
  logic          finish;
  logic [1:0]    st;
  logic [NW-1:0] n;
  logic [1:0]    rval;
  logic [1:0]    nv;

  always_ff @(posedge clk) begin
    if (op_we) op_mem[op_wa] <= op_wd;
    op_rd <= op_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_rd <= val_mem[val_ra];
  end
  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (left_we) left_mem[left_wa] <= left_wd;
    left_rd <= left_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (right_we) right_mem[right_wa] <= right_wd;
    right_rd <= right_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (l2n_we) l2n_mem[l2n_wa] <= l2n_wd;
    l2n_rd <= l2n_mem[l2n_ra];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  assign n    = node_total[NW-1:0];
  assign rval = (rc < NONE) ? val_rd : VAL_UNK;
  assign nv   = kleene_eval(opr, lval, rval, old);

  always_comb begin
    state_next       = state;
    stack_depth_next = stack_depth;
    node_total_next  = node_total;
    leaf_total_next  = leaf_total;
    root_value_next  = root_value;
    cmd_next         = cmd;
    cur_next         = cur;
    par_next         = par;
    rc_next          = rc;
    opr_next         = opr;
    old_next         = old;
    lval_next        = lval;
    q_pop            = 1'b0;
    finish           = 1'b0;
    st               = ST_OK;
    op_we = 1'b0; val_we = 1'b0; par_we = 1'b0; left_we = 1'b0;
    right_we = 1'b0; l2n_we = 1'b0; stk_we = 1'b0;
    op_wa = n; val_wa = n; par_wa = n; left_wa = n; right_wa = n;
    l2n_wa = leaf_total[NW-1:0]; stk_wa = stack_depth[NW-1:0];
    op_wd = cmd.op; val_wd = VAL_UNK; par_wd = NONE; left_wd = stk_rd;
    right_wd = NONE; l2n_wd = n; stk_wd = n;
    node_ra = cur; val_ra = cur; l2n_ra = '0; stk_ra = '0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && !rsp_valid) begin
          q_pop    = 1'b1;
          cmd_next = q_cmd;
          unique case (q_cmd.kind)
            KIND_BEGIN: begin
              stack_depth_next = '0;
              node_total_next  = '0;
              leaf_total_next  = '0;
              root_value_next  = VAL_UNK;
              finish           = 1'b1;
            end
            KIND_APPEND: begin
              if (node_total >= NONE) begin
                st = ST_MALFORMED; finish = 1'b1;
              end else if (q_cmd.is_leaf) begin
                op_we = 1'b1; op_wd = OP_NOT;
                val_we = 1'b1; par_we = 1'b1; right_we = 1'b1;
                l2n_we = 1'b1; stk_we = 1'b1;
                stack_depth_next = stack_depth + 1'b1;
                node_total_next  = node_total + 1'b1;
                leaf_total_next  = leaf_total + 1'b1;
                finish           = 1'b1;
              end else if (q_cmd.op_bad ||
                           stack_depth < (q_cmd.unary ? CW'(1) : CW'(2))) begin
                st = ST_MALFORMED; finish = 1'b1;
              end else begin
                op_we = 1'b1; op_wd = q_cmd.op;
                val_we = 1'b1; par_we = 1'b1; right_we = 1'b1;
                stk_ra     = NW'(stack_depth - 1'b1);
                state_next = S_POP1;
              end
            end
            KIND_SET: begin
              if (stack_depth != CW'(1)) begin
                st = ST_INCOMPLETE; finish = 1'b1;
              end else if (XW'(q_cmd.leaf) >= XW'(leaf_total)) begin
                st = ST_IGNORED; finish = 1'b1;
              end else begin
                l2n_ra     = NW'(q_cmd.leaf);
                state_next = S_SET1;
              end
            end
            default: begin
              root_value_next = VAL_UNK;
              cur_next        = '0;
              if (node_total == '0) finish = 1'b1;
              else state_next = S_CLR;
            end
          endcase
        end
      end
      S_POP1: begin
        par_we = 1'b1; par_wa = stk_rd; par_wd = CW'(n);
        if (cmd.unary) begin
          left_we = 1'b1;
          stk_we = 1'b1; stk_wa = NW'(stack_depth - 1'b1);
          node_total_next = node_total + 1'b1;
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          right_we = 1'b1; right_wd = CW'(stk_rd);
          stk_ra = NW'(stack_depth - CW'(2));
          state_next = S_POP2;
        end
      end
      S_POP2: begin
        par_we = 1'b1; par_wa = stk_rd; par_wd = CW'(n);
        left_we = 1'b1;
        stk_we = 1'b1; stk_wa = NW'(stack_depth - CW'(2));
        stack_depth_next = stack_depth - 1'b1;
        node_total_next  = node_total + 1'b1;
        finish = 1'b1;
        state_next = S_IDLE;
      end
      S_SET1: begin
        val_we = 1'b1; val_wa = l2n_rd; val_wd = cmd.value;
        node_ra = l2n_rd;
        state_next = S_SET2;
      end
      S_SET2: begin
        if (par_rd >= NONE) begin
          root_value_next = cmd.value;
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cur_next = par_rd[NW-1:0];
          node_ra  = par_rd[NW-1:0];
          val_ra   = par_rd[NW-1:0];
          state_next = S_W1;
        end
      end
      S_W1: begin
        old_next = val_rd;
        opr_next = op_rd;
        rc_next  = right_rd;
        par_next = par_rd;
        val_ra   = left_rd;
        state_next = S_W2;
      end
      S_W2: begin
        lval_next = val_rd;
        val_ra    = rc[NW-1:0];
        state_next = S_W3;
      end
      S_W3: begin
        val_we = 1'b1; val_wa = cur; val_wd = nv;
        if (nv == old) begin
          finish = 1'b1; state_next = S_IDLE;
        end else if (par >= NONE) begin
          root_value_next = nv;
          finish = 1'b1; state_next = S_IDLE;
        end else begin
          cur_next = par[NW-1:0];
          node_ra  = par[NW-1:0];
          val_ra   = par[NW-1:0];
          state_next = S_W1;
        end
      end
      S_CLR: begin
        val_we = 1'b1; val_wa = cur;
        if (CW'(cur) == node_total - 1'b1) begin
          finish = 1'b1; state_next = S_IDLE;
        end else begin
          cur_next = cur + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    if (finish) begin
      rsp_valid_next      = 1'b1;
      rsp_next.tree_state = root_value_next;
      rsp_next.status     = st;
    end
  end

  always_ff @(posedge clk) begin
    cmd  <= cmd_next;
    cur  <= cur_next;
    par  <= par_next;
    rc   <= rc_next;
    opr  <= opr_next;
    old  <= old_next;
    lval <= lval_next;
    rsp  <= rsp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_depth <= '0;
      node_total  <= '0;
      leaf_total  <= '0;
      root_value  <= VAL_UNK;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_depth <= stack_depth_next;
      node_total  <= node_total_next;
      leaf_total  <= leaf_total_next;
      root_value  <= root_value_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

endmodule

// ===== hw/rtl/three_valued_logic_tree_evaluator.sv =====
// Top level of the Kleene three-valued query tree evaluator.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_t  (kind, element, operator, leaf, value)
//   rsp      out        rsp_valid/rsp_stall   rsp_t  (tree_state, status)
//
// Begin, leaf append and rejected requests finish in the idle state; an operator append
// passes POP1 and, if binary, POP2; a clear sweeps every node; a set passes SET1 and SET2,
// then W1, W2, W3 per parent walked; the node memories' single read port sets the pace.
// The sequencer holds the next request while rsp_valid is high.
// Reset is synchronous and clears counters and control; node memories are not cleared.
// A two-entry queue keeps accepting requests, until full, while the sequencer or rsp is stalled.
module three_valued_logic_tree_evaluator import tvl_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  tvl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  tvl_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
